[rtl/core/exyzr_pkg.sv]
// ----------------------------------------------------------------------------
// exyzr_pkg
// Shared types, constants and tables of the Euler XYZ point rotator: the
// configuration request, the coefficient sequencer states, the CORDIC
// constants and the microprogram that builds the rotation matrix.
// ----------------------------------------------------------------------------
`default_nettype none

package exyzr_pkg;

    localparam int ANGLE_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_COEFF = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_Z = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam int CORDIC_Q          = 30;
    localparam int CORDIC_W          = 32;
    localparam int Z_W               = 34;
    localparam int PROD_W            = 64;
    localparam int TERM_W            = 34;
    localparam int ACC_W             = 35;
    localparam int ITER_W            = 5;
    localparam int CORDIC_MAX_STAGES = 24;

    localparam logic signed [CORDIC_W-1:0] CORDIC_START = 32'sd652032874;
    localparam logic signed [CORDIC_W-1:0] ONE_Q30      = 32'sh4000_0000;
    localparam logic signed [Z_W-1:0]      HALF_PI_Q30  = 34'sd1686629713;
    localparam logic signed [Z_W-1:0]      PI_Q30       = 34'sd3373259426;

    localparam logic [3:0] LAST_STEP = 4'd14;
    localparam logic [3:0] TMP_SXSY  = 4'd0;
    localparam logic [3:0] TMP_CXSY  = 4'd1;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [ANGLE_W-1:0]   data;
    } t_cfg_wr;

    typedef enum logic [2:0] {
        GEN_IDLE,
        GEN_CORDIC_LOAD,
        GEN_CORDIC_RUN,
        GEN_CORDIC_SAVE,
        GEN_MUL,
        GEN_ROUND,
        GEN_ACC,
        GEN_STORE
    } t_gen_state;

    typedef enum logic [3:0] {
        OP_CX,
        OP_SX,
        OP_CY,
        OP_SY,
        OP_CZ,
        OP_SZ,
        OP_SXSY,
        OP_CXSY,
        OP_ONE
    } t_opnd;

    typedef struct packed {
        t_opnd      a;
        t_opnd      b;
        logic       sub;
        logic       to_tmp;
        logic       last;
        logic [3:0] dest;
    } t_mstep;

    function automatic logic signed [CORDIC_W-1:0] atan_q30(input logic [ITER_W-1:0] i);
        logic signed [CORDIC_W-1:0] v;
        case (i)
            5'd0:    v = 32'sh3243F6A8;
            5'd1:    v = 32'sh1DAC6705;
            5'd2:    v = 32'sh0FADBAFC;
            5'd3:    v = 32'sh07F56EA6;
            5'd4:    v = 32'sh03FEAB76;
            5'd5:    v = 32'sh01FFD55B;
            5'd6:    v = 32'sh00FFFAAA;
            5'd7:    v = 32'sh007FFF55;
            5'd8:    v = 32'sh003FFFEA;
            5'd9:    v = 32'sh001FFFFD;
            5'd10:   v = 32'sh000FFFFF;
            5'd11:   v = 32'sh0007FFFF;
            5'd12:   v = 32'sh0003FFFF;
            5'd13:   v = 32'sh0001FFFF;
            5'd14:   v = 32'sh0000FFFF;
            5'd15:   v = 32'sh00007FFF;
            5'd16:   v = 32'sh00003FFF;
            5'd17:   v = 32'sh00001FFF;
            5'd18:   v = 32'sh00000FFF;
            5'd19:   v = 32'sh000007FF;
            5'd20:   v = 32'sh000003FF;
            5'd21:   v = 32'sh000001FF;
            5'd22:   v = 32'sh000000FF;
            5'd23:   v = 32'sh0000007F;
            default: v = 32'sh00000000;
        endcase
        return v;
    endfunction

    // The rows of R = Rx * Ry * Rz as a sequence of rounded products.
    function automatic t_mstep mat_step(input logic [3:0] k);
        t_mstep s;
        case (k)
            4'd0:    s = '{OP_SX,   OP_SY,  1'b0, 1'b1, 1'b0, TMP_SXSY};
            4'd1:    s = '{OP_CX,   OP_SY,  1'b0, 1'b1, 1'b0, TMP_CXSY};
            4'd2:    s = '{OP_CY,   OP_CZ,  1'b0, 1'b0, 1'b1, 4'd0};
            4'd3:    s = '{OP_CY,   OP_SZ,  1'b1, 1'b0, 1'b1, 4'd1};
            4'd4:    s = '{OP_SY,   OP_ONE, 1'b0, 1'b0, 1'b1, 4'd2};
            4'd5:    s = '{OP_SXSY, OP_CZ,  1'b0, 1'b0, 1'b0, 4'd3};
            4'd6:    s = '{OP_CX,   OP_SZ,  1'b0, 1'b0, 1'b1, 4'd3};
            4'd7:    s = '{OP_CX,   OP_CZ,  1'b0, 1'b0, 1'b0, 4'd4};
            4'd8:    s = '{OP_SXSY, OP_SZ,  1'b1, 1'b0, 1'b1, 4'd4};
            4'd9:    s = '{OP_SX,   OP_CY,  1'b1, 1'b0, 1'b1, 4'd5};
            4'd10:   s = '{OP_SX,   OP_SZ,  1'b0, 1'b0, 1'b0, 4'd6};
            4'd11:   s = '{OP_CXSY, OP_CZ,  1'b1, 1'b0, 1'b1, 4'd6};
            4'd12:   s = '{OP_CXSY, OP_SZ,  1'b0, 1'b0, 1'b0, 4'd7};
            4'd13:   s = '{OP_SX,   OP_CZ,  1'b0, 1'b0, 1'b1, 4'd7};
            4'd14:   s = '{OP_CX,   OP_CY,  1'b0, 1'b0, 1'b1, 4'd8};
            default: s = '{OP_ONE,  OP_ONE, 1'b0, 1'b0, 1'b1, 4'd8};
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

[rtl/core/exyzr_coeff_gen.sv]
// ----------------------------------------------------------------------------
// exyzr_coeff_gen
// Holds the three angles and the nine rotation coefficients. After an angle
// write it runs an iterative CORDIC for each axis and then a one-multiplier
// sequencer that forms and rounds the coefficients of R = Rx * Ry * Rz.
// ----------------------------------------------------------------------------
`default_nettype none

module exyzr_coeff_gen
    import exyzr_pkg::*;
#(
    parameter int COEFF_FRAC  = 16,
    parameter int TRIG_STAGES = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_cfg_wr                      i_cfg,
    output logic                              o_busy,
    output logic signed [COEFF_FRAC+1:0]      o_coeff [NUM_COEFF]
);

    localparam int COEFF_W = COEFF_FRAC + 2;
    localparam int SH      = CORDIC_Q - COEFF_FRAC;
    localparam int Q_W     = ACC_W - SH;
    localparam int N_ITER  = (TRIG_STAGES > CORDIC_MAX_STAGES) ? CORDIC_MAX_STAGES
                                                                : TRIG_STAGES;
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(N_ITER - 1);

    localparam logic signed [ACC_W-1:0] ACC_RND =
        {{(ACC_W-SH){1'b0}}, 1'b1, {(SH-1){1'b0}}};
    localparam logic signed [PROD_W-1:0] PROD_RND =
        {{(PROD_W-CORDIC_Q){1'b0}}, 1'b1, {(CORDIC_Q-1){1'b0}}};
    localparam logic signed [Q_W-1:0] CF_MAX =
        {{(Q_W-COEFF_W+1){1'b0}}, {(COEFF_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] CF_MIN = ~CF_MAX;

    t_gen_state                  r_state;
    t_gen_state                  n_state;
    logic [1:0]                  r_axis;
    logic [ITER_W-1:0]           r_iter;
    logic [3:0]                  r_step;
    logic signed [ANGLE_W-1:0]   r_angle_x;
    logic signed [ANGLE_W-1:0]   r_angle_y;
    logic signed [ANGLE_W-1:0]   r_angle_z;
    logic signed [COEFF_W-1:0]   r_coeff [NUM_COEFF];

    logic signed [CORDIC_W-1:0]  r_x;
    logic signed [CORDIC_W-1:0]  r_y;
    logic signed [Z_W-1:0]       r_z;
    logic                        r_neg;
    logic signed [CORDIC_W-1:0]  r_cos_x;
    logic signed [CORDIC_W-1:0]  r_sin_x;
    logic signed [CORDIC_W-1:0]  r_cos_y;
    logic signed [CORDIC_W-1:0]  r_sin_y;
    logic signed [CORDIC_W-1:0]  r_cos_z;
    logic signed [CORDIC_W-1:0]  r_sin_z;
    logic signed [CORDIC_W-1:0]  r_sxsy;
    logic signed [CORDIC_W-1:0]  r_cxsy;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [TERM_W-1:0]    r_term;
    logic signed [ACC_W-1:0]     r_acc;

    logic signed [ANGLE_W-1:0]   w_angle;
    logic signed [Z_W-1:0]       w_z0;
    logic signed [CORDIC_W-1:0]  w_dx;
    logic signed [CORDIC_W-1:0]  w_dy;
    logic signed [Z_W-1:0]       w_atan;
    t_mstep                      w_step;
    logic signed [CORDIC_W-1:0]  w_opa;
    logic signed [CORDIC_W-1:0]  w_opb;
    logic signed [PROD_W-1:0]    w_prod_rnd;
    logic signed [CORDIC_W-1:0]  w_cos;
    logic signed [CORDIC_W-1:0]  w_sin;

    function automatic logic signed [CORDIC_W-1:0] pick(input t_opnd op,
        input logic signed [CORDIC_W-1:0] cx, input logic signed [CORDIC_W-1:0] sx,
        input logic signed [CORDIC_W-1:0] cy, input logic signed [CORDIC_W-1:0] sy,
        input logic signed [CORDIC_W-1:0] cz, input logic signed [CORDIC_W-1:0] sz,
        input logic signed [CORDIC_W-1:0] sxsy, input logic signed [CORDIC_W-1:0] cxsy);
        logic signed [CORDIC_W-1:0] v;
        case (op)
            OP_CX:   v = cx;
            OP_SX:   v = sx;
            OP_CY:   v = cy;
            OP_SY:   v = sy;
            OP_CZ:   v = cz;
            OP_SZ:   v = sz;
            OP_SXSY: v = sxsy;
            OP_CXSY: v = cxsy;
            default: v = ONE_Q30;
        endcase
        return v;
    endfunction

    function automatic logic signed [COEFF_W-1:0] to_coeff(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        logic signed [Q_W-1:0]   q;
        logic signed [COEFF_W-1:0] r;
        t = v + ACC_RND;
        q = $signed(t[ACC_W-1:SH]);
        if (q > CF_MAX) begin
            r = CF_MAX[COEFF_W-1:0];
        end else if (q < CF_MIN) begin
            r = CF_MIN[COEFF_W-1:0];
        end else begin
            r = q[COEFF_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        case (r_axis)
            AXIS_X:  w_angle = r_angle_x;
            AXIS_Y:  w_angle = r_angle_y;
            default: w_angle = r_angle_z;
        endcase
    end

    assign w_z0       = {w_angle[ANGLE_W-1], w_angle, 17'b0};
    assign w_dx       = r_y >>> r_iter;
    assign w_dy       = r_x >>> r_iter;
    assign w_atan     = Z_W'(atan_q30(r_iter));
    assign w_step     = mat_step(r_step);
    assign w_opa      = pick(w_step.a, r_cos_x, r_sin_x, r_cos_y, r_sin_y,
                             r_cos_z, r_sin_z, r_sxsy, r_cxsy);
    assign w_opb      = pick(w_step.b, r_cos_x, r_sin_x, r_cos_y, r_sin_y,
                             r_cos_z, r_sin_z, r_sxsy, r_cxsy);
    assign w_prod_rnd = r_prod + PROD_RND;
    assign w_cos      = r_neg ? -r_x : r_x;
    assign w_sin      = r_neg ? -r_y : r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= GEN_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_busy  = (r_state != GEN_IDLE);
        case (r_state)
            GEN_IDLE: begin
                if (i_cfg.valid && (i_cfg.index inside {CFG_ANGLE_X, CFG_ANGLE_Y,
                                                        CFG_ANGLE_Z})) begin
                    n_state = GEN_CORDIC_LOAD;
                end
            end
            GEN_CORDIC_LOAD: begin
                n_state = GEN_CORDIC_RUN;
            end
            GEN_CORDIC_RUN: begin
                if (r_iter == LAST_ITER) begin
                    n_state = GEN_CORDIC_SAVE;
                end
            end
            GEN_CORDIC_SAVE: begin
                n_state = (r_axis == AXIS_Z) ? GEN_MUL : GEN_CORDIC_LOAD;
            end
            GEN_MUL: begin
                n_state = GEN_ROUND;
            end
            GEN_ROUND: begin
                n_state = GEN_ACC;
            end
            GEN_ACC: begin
                n_state = (w_step.to_tmp || !w_step.last) ? GEN_MUL : GEN_STORE;
            end
            GEN_STORE: begin
                n_state = (r_step == LAST_STEP) ? GEN_IDLE : GEN_MUL;
            end
            default: begin
                n_state = GEN_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis    <= AXIS_X;
            r_iter    <= '0;
            r_step    <= '0;
            r_angle_x <= '0;
            r_angle_y <= '0;
            r_angle_z <= '0;
            for (int i = 0; i < NUM_COEFF; i++) begin
                r_coeff[i] <= (i % 4 == 0) ? {2'b01, {COEFF_FRAC{1'b0}}} : '0;
            end
        end else begin
            case (r_state)
                GEN_IDLE: begin
                    r_axis <= AXIS_X;
                    if (i_cfg.valid) begin
                        case (i_cfg.index)
                            CFG_ANGLE_X: r_angle_x <= $signed(i_cfg.data);
                            CFG_ANGLE_Y: r_angle_y <= $signed(i_cfg.data);
                            CFG_ANGLE_Z: r_angle_z <= $signed(i_cfg.data);
                            default: ;
                        endcase
                    end
                end
                GEN_CORDIC_LOAD: begin
                    r_iter <= '0;
                end
                GEN_CORDIC_RUN: begin
                    r_iter <= r_iter + 1'b1;
                end
                GEN_CORDIC_SAVE: begin
                    r_axis <= r_axis + 1'b1;
                    r_step <= '0;
                end
                GEN_ACC: begin
                    if (w_step.to_tmp || !w_step.last) begin
                        r_step <= r_step + 1'b1;
                    end
                end
                GEN_STORE: begin
                    r_coeff[w_step.dest] <= to_coeff(r_acc);
                    r_step               <= r_step + 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            GEN_CORDIC_LOAD: begin
                r_x <= CORDIC_START;
                r_y <= '0;
                if (w_z0 > HALF_PI_Q30) begin
                    r_z   <= w_z0 - PI_Q30;
                    r_neg <= 1'b1;
                end else if (w_z0 < -HALF_PI_Q30) begin
                    r_z   <= w_z0 + PI_Q30;
                    r_neg <= 1'b1;
                end else begin
                    r_z   <= w_z0;
                    r_neg <= 1'b0;
                end
            end
            GEN_CORDIC_RUN: begin
                if (!r_z[Z_W-1]) begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_atan;
                end else begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_atan;
                end
            end
            GEN_CORDIC_SAVE: begin
                r_acc <= '0;
                case (r_axis)
                    AXIS_X: begin
                        r_cos_x <= w_cos;
                        r_sin_x <= w_sin;
                    end
                    AXIS_Y: begin
                        r_cos_y <= w_cos;
                        r_sin_y <= w_sin;
                    end
                    default: begin
                        r_cos_z <= w_cos;
                        r_sin_z <= w_sin;
                    end
                endcase
            end
            GEN_MUL: begin
                r_prod <= PROD_W'(w_opa) * PROD_W'(w_opb);
            end
            GEN_ROUND: begin
                r_term <= $signed(w_prod_rnd[PROD_W-1:CORDIC_Q]);
            end
            GEN_ACC: begin
                if (w_step.to_tmp) begin
                    if (w_step.dest == TMP_SXSY) begin
                        r_sxsy <= r_term[CORDIC_W-1:0];
                    end else begin
                        r_cxsy <= r_term[CORDIC_W-1:0];
                    end
                end else if (w_step.sub) begin
                    r_acc <= r_acc - ACC_W'(r_term);
                end else begin
                    r_acc <= r_acc + ACC_W'(r_term);
                end
            end
            GEN_STORE: begin
                r_acc <= '0;
            end
            default: ;
        endcase
    end

    assign o_coeff = r_coeff;

endmodule

`default_nettype wire

[rtl/core/euler_xyz_point_rotator_unit.sv]
// ----------------------------------------------------------------------------
// euler_xyz_point_rotator_unit
// Rotates a stream of 3D points by R = Rx * Ry * Rz, set up from three Euler
// angles. Each point passes a four-stage multiply, add, round and saturate
// pipeline against nine coefficients held by the coefficient generator.
//
//   Channel  Direction  Handshake              Payload
//   in       input      i_in_valid/o_in_stall  i_in_x, i_in_y, i_in_z
//   out      output     o_out_valid/i_out_stall o_out_x, o_out_y, o_out_z
//   cfg      input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One point is accepted per cycle while the unit is neither busy nor stalled;
// each result passes the product, partial-sum, sum and output registers in turn.
// An angle write rebuilds the matrix with the shared CORDIC and the single
// coefficient multiplier; input and configuration wait meanwhile.
// After reset the matrix is the identity. Each stage holds while the next one
// is full and stalled, so empty stages still take new requests.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_xyz_point_rotator_unit
    import exyzr_pkg::*;
#(
    parameter int COORD_WIDTH = 24,
    parameter int COEFF_FRAC  = 16,
    parameter int TRIG_STAGES = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [COORD_WIDTH-1:0] i_in_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_in_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_in_z,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [COORD_WIDTH-1:0]      o_out_x,
    output logic signed [COORD_WIDTH-1:0]      o_out_y,
    output logic signed [COORD_WIDTH-1:0]      o_out_z,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [ANGLE_W-1:0]            i_cfg_data
);

    localparam int COEFF_W = COEFF_FRAC + 2;
    localparam int PW      = COEFF_W + COORD_WIDTH;
    localparam int SUM_W   = PW + 2;
    localparam int SH_W    = SUM_W - COEFF_FRAC;

    localparam logic signed [SUM_W-1:0] RND =
        {{(SUM_W-COEFF_FRAC){1'b0}}, 1'b1, {(COEFF_FRAC-1){1'b0}}};
    localparam logic signed [SH_W-1:0] OUT_MAX =
        {{(SH_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [SH_W-1:0] OUT_MIN = ~OUT_MAX;

    t_cfg_wr                       w_cfg;
    logic                          w_busy;
    logic signed [COEFF_W-1:0]     w_coeff [NUM_COEFF];
    logic signed [COORD_WIDTH-1:0] w_in [3];
    logic                          w_en1;
    logic                          w_en2;
    logic                          w_en3;
    logic                          w_en4;
    logic                          w_take;
    logic signed [SH_W-1:0]        w_sh [3];
    logic signed [COORD_WIDTH-1:0] w_sat [3];

    logic                          r_v1;
    logic                          r_v2;
    logic                          r_v3;
    logic                          r_v4;
    logic signed [PW-1:0]          r_p1 [NUM_COEFF];
    logic signed [SUM_W-1:0]       r_s2a [3];
    logic signed [SUM_W-1:0]       r_s2b [3];
    logic signed [SUM_W-1:0]       r_s3 [3];
    logic signed [COORD_WIDTH-1:0] r_out [3];

    assign o_cfg_ready = !w_busy;
    assign w_cfg.valid = i_cfg_valid && !w_busy;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    exyzr_coeff_gen #(
        .COEFF_FRAC  (COEFF_FRAC),
        .TRIG_STAGES (TRIG_STAGES)
    ) u_coeff_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .o_busy  (w_busy),
        .o_coeff (w_coeff)
    );

    assign w_in[0] = i_in_x;
    assign w_in[1] = i_in_y;
    assign w_in[2] = i_in_z;

    assign w_en4      = !r_v4 || !i_out_stall;
    assign w_en3      = !r_v3 || w_en4;
    assign w_en2      = !r_v2 || w_en3;
    assign w_en1      = !r_v1 || w_en2;
    assign o_in_stall = w_busy || !w_en1;
    assign w_take     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= w_take;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_sh[r] = $signed(r_s3[r][SUM_W-1:COEFF_FRAC]);
            if (w_sh[r] > OUT_MAX) begin
                w_sat[r] = OUT_MAX[COORD_WIDTH-1:0];
            end else if (w_sh[r] < OUT_MIN) begin
                w_sat[r] = OUT_MIN[COORD_WIDTH-1:0];
            end else begin
                w_sat[r] = w_sh[r][COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_p1[r*3+c] <= PW'(w_coeff[r*3+c]) * PW'(w_in[c]);
                end
            end
        end
        if (w_en2) begin
            for (int r = 0; r < 3; r++) begin
                r_s2a[r] <= SUM_W'(r_p1[r*3]) + SUM_W'(r_p1[r*3+1]);
                r_s2b[r] <= SUM_W'(r_p1[r*3+2]) + RND;
            end
        end
        if (w_en3) begin
            for (int r = 0; r < 3; r++) begin
                r_s3[r] <= r_s2a[r] + r_s2b[r];
            end
        end
        if (w_en4) begin
            for (int r = 0; r < 3; r++) begin
                r_out[r] <= w_sat[r];
            end
        end
    end

    assign o_out_valid = r_v4;
    assign o_out_x     = r_out[0];
    assign o_out_y     = r_out[1];
    assign o_out_z     = r_out[2];

endmodule

`default_nettype wire
